// File: src/mrle_pkg.sv
// shared types and constants for the mask run-length encoder with bounding box
// used by mrle_core, mrle_obuf and mask_run_length_encoder_bbox
`default_nettype none

package mrle_pkg;

    // default frame size limits, handed to the top level parameters
    localparam int unsigned MAX_WIDTH_DEF  = 4096;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    // configuration register width and reset values, register port widths
    localparam int unsigned REG_W        = 13;
    localparam int unsigned MASK_W_RST   = 640;
    localparam int unsigned MASK_H_RST   = 640;
    localparam int unsigned APB_AW       = 3;
    localparam int unsigned APB_DW       = 32;

    // payload field widths
    localparam int unsigned PIX_W        = 8;
    localparam int unsigned IDX_W        = 24;
    localparam int unsigned LEN_W        = 25;
    localparam int unsigned BOX_W        = 13;
    localparam int unsigned IN_TDATA_W   = 8;
    localparam int unsigned OUT_TDATA_W  = 104;
    localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - (IDX_W + LEN_W + 1 + 4 * BOX_W);

    // result queue depth (power of two, at least two)
    localparam int unsigned OBUF_DEPTH   = 4;

    typedef enum logic {
        KIND_RUN = 1'b0,
        KIND_SUM = 1'b1
    } t_kind;

    typedef enum logic {
        REG_MASK_WIDTH  = 1'b0,
        REG_MASK_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  run_begin;
        logic [LEN_W-1:0]  run_length;
        logic              fg_present;
        logic [BOX_W-1:0]  box_x1;
        logic [BOX_W-1:0]  box_y1;
        logic [BOX_W-1:0]  box_x2;
        logic [BOX_W-1:0]  box_y2;
        logic              last;
    } t_result;

    typedef struct packed {
        logic run_vld;
        logic sum_vld;
    } t_push;

endpackage

`default_nettype wire

// File: src/mask_run_length_encoder_bbox.sv
// top level of the mask run-length encoder with bounding box: config registers,
// scan core and result queue; depends on mrle_pkg, mrle_core and mrle_obuf
//
// Takes a binary mask one byte per transfer in row-major order (nonzero is
// foreground) and emits each maximal foreground run as a run record (start
// index, length) on the transfer that ends it; runs are not split at row ends.
// The frame's last pixel also produces an end-of-frame summary with tlast set,
// carrying a has-foreground flag and the bounding box (x1, y1 inclusive; x2, y2
// exclusive, all zero for an empty frame); a run crossing a row end widens the
// box to the full width. Frame size comes from mask_width (address 0) and
// mask_height (address 4); 0 acts as 1 and values above the limits are clamped.
// Any register write restarts the frame. Write registers only while the block
// is idle. Throughput is one pixel per cycle: all work for a pixel sits in one
// combinational step ahead of a four-entry result queue, and the input stalls
// only while that queue has fewer than two free entries (a frame's last pixel
// can produce two results). Results are registered in the queue. There is
// no clearing pass after reset.
`default_nettype none

module mask_run_length_encoder_bbox #(
    parameter int unsigned MAX_WIDTH  = mrle_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = mrle_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // pixel stream in
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [mrle_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // pixel[7:0]
    // result stream out
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // run start[23:0], run_length[48:24], foreground flag[49], box_x1[62:50],
    // box_y1[75:63], box_x2[88:76], box_y2[101:89], zero pad[103:102]
    output logic [mrle_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                    m_axis_tuser,   // kind[0]
    output logic                                    m_axis_tlast,
    // register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mrle_pkg::APB_AW-1:0]        paddr,
    input  wire logic [mrle_pkg::APB_DW-1:0]        pwdata,
    output logic [mrle_pkg::APB_DW-1:0]             prdata,
    output logic                                    pready
);

    localparam int unsigned CW      = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW      = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned REG_W   = mrle_pkg::REG_W;
    localparam int unsigned EffWRst =
        (mrle_pkg::MASK_W_RST > MAX_WIDTH)  ? MAX_WIDTH  : mrle_pkg::MASK_W_RST;
    localparam int unsigned EffHRst =
        (mrle_pkg::MASK_H_RST > MAX_HEIGHT) ? MAX_HEIGHT : mrle_pkg::MASK_H_RST;

    // raw register values (read back as written)
    logic [REG_W-1:0] r_mask_width;
    logic [REG_W-1:0] r_mask_height;
    // clamped frame size, kept registered to keep the clamp off the pixel path
    logic [CW-1:0]    r_eff_w;
    logic [CW-1:0]    r_w_last;
    logic [RW-1:0]    r_h_last;

    logic             cfg_wr;
    mrle_pkg::t_reg_idx cfg_idx;
    logic [REG_W-1:0] wr_val;
    logic [CW-1:0]    n_eff_w;
    logic [RW-1:0]    n_eff_h;

    logic             take;
    logic             room;
    mrle_pkg::t_push  push;
    mrle_pkg::t_result run_rec;
    mrle_pkg::t_result sum_rec;
    mrle_pkg::t_result out_rec;

    // ---------------------------------------------------------------------
    // register port: no wait states, a write also restarts the frame
    // ---------------------------------------------------------------------
    always_comb begin
        pready  = 1'b1;
        cfg_wr  = psel & penable & pwrite & pready;
        cfg_idx = mrle_pkg::t_reg_idx'(paddr[2]);
        wr_val  = pwdata[REG_W-1:0];

        // clamp to 1..max
        if (wr_val == '0) begin
            n_eff_w = CW'(1);
            n_eff_h = RW'(1);
        end else begin
            n_eff_w = (32'(wr_val) > 32'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : CW'(wr_val);
            n_eff_h = (32'(wr_val) > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(wr_val);
        end

        unique case (cfg_idx)
            mrle_pkg::REG_MASK_WIDTH:  prdata = 32'(r_mask_width);
            mrle_pkg::REG_MASK_HEIGHT: prdata = 32'(r_mask_height);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_width  <= REG_W'(mrle_pkg::MASK_W_RST);
            r_mask_height <= REG_W'(mrle_pkg::MASK_H_RST);
            r_eff_w       <= CW'(EffWRst);
            r_w_last      <= CW'(EffWRst - 1);
            r_h_last      <= RW'(EffHRst - 1);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                mrle_pkg::REG_MASK_WIDTH: begin
                    r_mask_width <= wr_val;
                    r_eff_w      <= n_eff_w;
                    r_w_last     <= n_eff_w - CW'(1);
                end
                mrle_pkg::REG_MASK_HEIGHT: begin
                    r_mask_height <= wr_val;
                    r_h_last      <= n_eff_h - RW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // pixel side: accept whenever the queue can take two results
    // ---------------------------------------------------------------------
    assign s_axis_tready = room;
    assign take          = s_axis_tvalid & room;

    mrle_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (cfg_wr),
        .i_eff_w    (r_eff_w),
        .i_w_last   (r_w_last),
        .i_h_last   (r_h_last),
        .i_take     (take),
        .i_pixel    (s_axis_tdata[mrle_pkg::PIX_W-1:0]),
        .o_push     (push),
        .o_run_rec  (run_rec),
        .o_sum_rec  (sum_rec)
    );

    mrle_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_run      (run_rec),
        .i_sum      (sum_rec),
        .o_room     (room),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (out_rec)
    );

    // result packing, first field in the low bits
    assign m_axis_tdata = {{mrle_pkg::OUT_PAD_W{1'b0}},
                           out_rec.box_y2, out_rec.box_x2,
                           out_rec.box_y1, out_rec.box_x1,
                           out_rec.fg_present,
                           out_rec.run_length, out_rec.run_begin};
    assign m_axis_tuser = out_rec.kind;
    assign m_axis_tlast = out_rec.last;

`ifndef SYNTH
    // only summaries close a frame
    a_last_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (out_rec.kind == mrle_pkg::KIND_SUM)))
        else $error("tlast does not match result kind");

    // a run record always covers at least one pixel
    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_rec.kind == mrle_pkg::KIND_RUN) |->
            (out_rec.run_length != '0))
        else $error("run record with zero length");

    // a nonempty box is properly ordered
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_rec.kind == mrle_pkg::KIND_SUM && out_rec.fg_present)
            |-> ((out_rec.box_x1 < out_rec.box_x2) && (out_rec.box_y1 < out_rec.box_y2)))
        else $error("bounding box corners out of order");

    // nothing is pushed without an accepted pixel
    a_push_needs_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.run_vld || push.sum_vld) |-> take)
        else $error("result pushed without an accepted pixel");
`endif

endmodule

`default_nettype wire

// File: src/mrle_core.sv
// per-pixel scan state: position, open run and bounding box, one pixel per cycle while i_take is set
// depends on mrle_pkg
`default_nettype none

module mrle_core #(
    parameter int unsigned MAX_WIDTH  = mrle_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = mrle_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_restart,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]        i_eff_w,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]        i_w_last,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]       i_h_last,
    input  wire logic                                  i_take,
    input  wire logic [mrle_pkg::PIX_W-1:0]            i_pixel,
    output mrle_pkg::t_push                            o_push,
    output mrle_pkg::t_result                          o_run_rec,
    output mrle_pkg::t_result                          o_sum_rec
);

    localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned IDX_W = mrle_pkg::IDX_W;
    localparam int unsigned LEN_W = mrle_pkg::LEN_W;
    localparam int unsigned BOX_W = mrle_pkg::BOX_W;

    logic [CW-1:0]    r_pos_x,    n_pos_x;
    logic [RW-1:0]    r_pos_y,    n_pos_y;
    logic [IDX_W-1:0] r_pix_idx,  n_pix_idx;
    logic             r_in_run,   n_in_run;
    logic [IDX_W-1:0] r_orun_start, n_orun_start;
    logic [CW-1:0]    r_orun_x,   n_orun_x;
    logic [RW-1:0]    r_orun_y,   n_orun_y;
    logic             r_seen,     n_seen;
    logic [CW-1:0]    r_min_col,  n_min_col;
    logic [RW-1:0]    r_min_row,  n_min_row;
    logic [CW-1:0]    r_max_col,  n_max_col;
    logic [RW-1:0]    r_max_row,  n_max_row;

    logic             fg;
    logic             close_bg;
    logic             close_eof;
    logic             do_close;
    logic             open_new;
    logic             eof;
    logic [IDX_W-1:0] c_start;
    logic [CW-1:0]    c_x0;
    logic [RW-1:0]    c_y0;
    logic [CW-1:0]    ex;
    logic [RW-1:0]    ey;
    logic [CW-1:0]    ex_p1;
    logic [RW-1:0]    ey_p1;
    logic [LEN_W-1:0] end_next;
    logic [LEN_W-1:0] run_len;

    always_comb begin
        fg        = (i_pixel != '0);
        close_bg  = r_in_run & ~fg;
        eof       = (r_pos_x >= i_w_last) & (r_pos_y >= i_h_last);
        close_eof = eof & fg;
        do_close  = close_bg | close_eof;
        open_new  = fg & ~r_in_run;

        c_start = open_new ? r_pix_idx : r_orun_start;
        c_x0    = open_new ? r_pos_x   : r_orun_x;
        c_y0    = open_new ? r_pos_y   : r_orun_y;

        // last pixel of the closing run
        if (close_eof) begin
            ex       = r_pos_x;
            ey       = r_pos_y;
            end_next = LEN_W'(r_pix_idx) + LEN_W'(1);
        end else if (r_pos_x == '0) begin
            ex       = i_w_last;
            ey       = (r_pos_y == '0) ? '0 : r_pos_y - RW'(1);
            end_next = LEN_W'(r_pix_idx);
        end else begin
            ex       = r_pos_x - CW'(1);
            ey       = r_pos_y;
            end_next = LEN_W'(r_pix_idx);
        end
        ex_p1   = ex + CW'(1);
        ey_p1   = ey + RW'(1);
        run_len = end_next - LEN_W'(c_start);

        // box update from the closing run
        n_seen    = r_seen;
        n_min_col = r_min_col;
        n_min_row = r_min_row;
        n_max_col = r_max_col;
        n_max_row = r_max_row;
        if (do_close) begin
            n_seen    = 1'b1;
            n_min_row = (c_y0 < r_min_row) ? c_y0 : r_min_row;
            n_max_row = (ey_p1 > r_max_row) ? ey_p1 : r_max_row;
            if (c_y0 == ey) begin
                n_min_col = (c_x0 < r_min_col) ? c_x0 : r_min_col;
                n_max_col = (ex_p1 > r_max_col) ? ex_p1 : r_max_col;
            end else begin
                // run wraps a row end: full width
                n_min_col = '0;
                n_max_col = i_eff_w;
            end
        end

        // scan position and open run
        n_pix_idx    = r_pix_idx + IDX_W'(1);
        n_in_run     = fg;
        n_orun_start = c_start;
        n_orun_x     = c_x0;
        n_orun_y     = c_y0;
        if (r_pos_x >= i_w_last) begin
            n_pos_x = '0;
            n_pos_y = r_pos_y + RW'(1);
        end else begin
            n_pos_x = r_pos_x + CW'(1);
            n_pos_y = r_pos_y;
        end
    end

    always_comb begin
        o_push.run_vld = i_take & do_close;
        o_push.sum_vld = i_take & eof;

        o_run_rec                = '0;
        o_run_rec.kind           = mrle_pkg::KIND_RUN;
        o_run_rec.run_begin      = c_start;
        o_run_rec.run_length     = run_len;

        o_sum_rec                = '0;
        o_sum_rec.kind           = mrle_pkg::KIND_SUM;
        o_sum_rec.last           = 1'b1;
        if (n_seen) begin
            o_sum_rec.fg_present     = 1'b1;
            o_sum_rec.box_x1         = BOX_W'(n_min_col);
            o_sum_rec.box_y1         = BOX_W'(n_min_row);
            o_sum_rec.box_x2         = BOX_W'(n_max_col);
            o_sum_rec.box_y2         = BOX_W'(n_max_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart || (i_take && eof)) begin
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_pix_idx    <= '0;
            r_in_run     <= 1'b0;
            r_orun_start <= '0;
            r_orun_x     <= '0;
            r_orun_y     <= '0;
            r_seen       <= 1'b0;
            // min seeds only need to be at or above the frame size
            r_min_col    <= '1;
            r_min_row    <= '1;
            r_max_col    <= '0;
            r_max_row    <= '0;
        end else if (i_take) begin
            r_pos_x      <= n_pos_x;
            r_pos_y      <= n_pos_y;
            r_pix_idx    <= n_pix_idx;
            r_in_run     <= n_in_run;
            r_orun_start <= n_orun_start;
            r_orun_x     <= n_orun_x;
            r_orun_y     <= n_orun_y;
            r_seen       <= n_seen;
            r_min_col    <= n_min_col;
            r_min_row    <= n_min_row;
            r_max_col    <= n_max_col;
            r_max_row    <= n_max_row;
        end
    end

endmodule

`default_nettype wire

// File: src/mrle_obuf.sv
// result queue: takes up to two results per cycle, hands out one per transfer
// depends on mrle_pkg
`default_nettype none

module mrle_obuf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mrle_pkg::t_push    i_push,
    input  wire mrle_pkg::t_result  i_run,
    input  wire mrle_pkg::t_result  i_sum,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output mrle_pkg::t_result       o_data
);

    localparam int unsigned DEPTH = mrle_pkg::OBUF_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mrle_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  push_n;
    logic              pop;
    logic [PTR_W-1:0]  wp_next;
    mrle_pkg::t_result first;

    always_comb begin
        push_n  = CNT_W'(i_push.run_vld) + CNT_W'(i_push.sum_vld);
        pop     = (r_count != '0) && i_ready;
        wp_next = r_wp + PTR_W'(1);
        first   = i_push.run_vld ? i_run : i_sum;
        o_room  = (r_count <= CNT_W'(DEPTH - 2));
        o_valid = (r_count != '0);
        o_data  = r_mem[r_rp];
    end

    // run record goes ahead of the summary when both come from one pixel
    always_ff @(posedge i_clk) begin
        if (i_push.run_vld || i_push.sum_vld) begin
            r_mem[r_wp] <= first;
        end
        if (i_push.run_vld && i_push.sum_vld) begin
            r_mem[wp_next] <= i_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PTR_W'(push_n);
            if (pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            r_count <= r_count + push_n - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire
